[rtl/bpsk_pkg.sv]
// Package: shared types, constants and the CORDIC arctangent table.
`default_nettype none
package bpsk_pkg;

  localparam int unsigned MaxSamplesDef  = 1024;
  localparam int unsigned CordicStepsDef = 16;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_DIFF   = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] cur_i;
    logic signed [15:0] cur_q;
    logic signed [15:0] prev_i;
    logic signed [15:0] prev_q;
  } in_t;

  typedef struct packed {
    logic               bit_res;
    logic               empty_res;
    logic signed [15:0] phase_error;
    logic signed [31:0] amplitude_error;
    logic [10:0]        sample_count;
    logic               overflow;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       clear;
    logic       cordic_load;
    logic       cordic_sel_prev;
    logic       cordic_step;
    logic       grab_cur;
    logic       accum;
    logic       div_load_phase;
    logic       div_load_pow;
    logic       div_step;
    logic       div_grab_phase;
    logic       out_load;
    logic [4:0] k;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       count_zero;
  } st_t;

  // atan(2^-k) with 2^31 = pi.
  function automatic logic [31:0] atan_f(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/bpsk_symbol_decider.sv]
// Top level: BPSK hard-decision symbol decider.
//
//   Channel  Direction  Handshake             Beat
//   in       input      in_valid_i/in_ready_o  in_data_i  (in_t)
//   out      output     out_valid_o/out_ready_i out_data_o (out_t)
//
// A new beat is taken only once the previous command is done. A sample command
// runs the single iterative CORDIC unit once and a differential command runs it
// twice. Decode runs the one-bit-per-cycle divider for phase error and then for
// power; an empty decode skips both divisions, and clear is applied in the idle
// state.
// Reset clears all accumulators. A result waiting in the output register stalls
// only a later decode; other commands continue.
`default_nettype none
module bpsk_symbol_decider import bpsk_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = MaxSamplesDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  ctl_t ctl;
  st_t  st;

  bpsk_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_data_i.command),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  bpsk_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .ctl_i     (ctl),
    .st_o      (st),
    .out_data_o(out_data_o)
  );

endmodule
`default_nettype wire

[rtl/bpsk_datapath.sv]
// Datapath: item register, iterative CORDIC, accumulators, divider, result register.
`default_nettype none
module bpsk_datapath import bpsk_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire ctl_t ctl_i,
  output st_t       st_o,
  output out_t      out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AbsW = 16 + CntW;
  localparam int unsigned SumW = 17 + CntW;
  localparam int unsigned PerW = 18 + CntW;
  localparam int unsigned DW   = 32 + CntW;

  in_t item_q;

  logic signed [35:0] x_q, y_q;
  logic [31:0]        z_q;
  logic               zero_q;
  logic [15:0]        cur_ph_q;
  logic [31:0]        pow_q;

  logic [AbsW-1:0]        abs_q;
  logic signed [SumW-1:0] sum_q;
  logic [CntW-1:0]        neg_q;
  logic [DW-1:0]          psum_q;
  logic [CntW-1:0]        cnt_q;
  logic                   drop_q;

  logic [DW-1:0]   dvd_q;
  logic [CntW-1:0] rem_q;
  logic            qneg_q;
  logic            bit_q;
  logic [15:0]     perr_q;
  out_t            out_q;

  // CORDIC source and step.
  logic signed [15:0] src_i, src_q;
  logic signed [16:0] ax, ay;
  logic signed [35:0] xs, ys;
  logic [31:0]        zr;
  logic [15:0]        phase;
  logic [15:0]        code;
  logic signed [16:0] p_ext;
  logic [16:0]        p_abs;
  logic               bit_d;
  logic signed [PerW-1:0] adj, num;
  logic [PerW-1:0]    mag;
  logic [CntW:0]      rem_sh;
  logic               ge;

  always_comb begin
    src_i = ctl_i.cordic_sel_prev ? item_q.prev_i : item_q.cur_i;
    src_q = ctl_i.cordic_sel_prev ? item_q.prev_q : item_q.cur_q;
    ax = src_i[15] ? -17'(src_i) : 17'(src_i);
    ay = src_i[15] ? -17'(src_q) : 17'(src_q);
    xs = x_q >>> ctl_i.k;
    ys = y_q >>> ctl_i.k;
    zr = z_q + 32'h0000_8000;
    phase = zero_q ? 16'd0 : zr[31:16];
    code = (item_q.command == CMD_DIFF) ? (cur_ph_q - phase) : phase;
    p_ext = 17'(signed'(code));
    p_abs = p_ext[16] ? unsigned'(-p_ext) : unsigned'(p_ext);
    bit_d = abs_q >= AbsW'({cnt_q, 14'b0});
    adj = (PerW'({neg_q, 1'b0}) - PerW'(cnt_q)) <<< 15;
    num = PerW'(sum_q) + (bit_d ? adj : '0);
    mag = num[PerW-1] ? unsigned'(-num) : unsigned'(num);
    rem_sh = {rem_q, dvd_q[DW-1]};
    ge = rem_sh >= (CntW+1)'(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      item_q <= in_data_i;
    end
    if (ctl_i.cordic_load) begin
      zero_q <= (src_i == 16'sd0) && (src_q == 16'sd0);
      x_q <= {{3{ax[16]}}, ax, 16'b0};
      y_q <= {{3{ay[16]}}, ay, 16'b0};
      z_q <= src_i[15] ? 32'h8000_0000 : 32'h0;
      if (!ctl_i.cordic_sel_prev) begin
        pow_q <= 32'(item_q.cur_i) * 32'(item_q.cur_i)
               + 32'(item_q.cur_q) * 32'(item_q.cur_q);
      end
    end else if (ctl_i.cordic_step) begin
      if (!y_q[35]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_f(ctl_i.k);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_f(ctl_i.k);
      end
    end
    if (ctl_i.grab_cur) begin
      cur_ph_q <= phase;
    end
    if (ctl_i.div_load_phase) begin
      bit_q  <= bit_d;
      qneg_q <= num[PerW-1];
      dvd_q  <= DW'(mag);
      rem_q  <= '0;
    end else if (ctl_i.div_load_pow) begin
      dvd_q <= psum_q;
      rem_q <= '0;
    end else if (ctl_i.div_step) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= ge ? CntW'(rem_sh - (CntW+1)'(cnt_q)) : rem_sh[CntW-1:0];
    end
    if (ctl_i.div_grab_phase) begin
      perr_q <= qneg_q ? -dvd_q[15:0] : dvd_q[15:0];
    end
    if (ctl_i.out_load) begin
      if (cnt_q == '0) begin
        out_q.bit_res         <= 1'b0;
        out_q.empty_res       <= 1'b1;
        out_q.phase_error     <= '0;
        out_q.amplitude_error <= '0;
        out_q.sample_count    <= '0;
        out_q.overflow        <= 1'b0;
      end else begin
        out_q.bit_res         <= bit_q;
        out_q.empty_res       <= 1'b0;
        out_q.phase_error     <= perr_q;
        out_q.amplitude_error <= dvd_q[31:0] - 32'h4000_0000;
        out_q.sample_count    <= 11'(cnt_q);
        out_q.overflow        <= drop_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q  <= '0;
      sum_q  <= '0;
      neg_q  <= '0;
      psum_q <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (ctl_i.clear) begin
      abs_q  <= '0;
      sum_q  <= '0;
      neg_q  <= '0;
      psum_q <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (ctl_i.accum) begin
      if (cnt_q >= CntW'(MAX_SAMPLES)) begin
        drop_q <= 1'b1;
      end else begin
        sum_q  <= sum_q + SumW'(p_ext);
        abs_q  <= abs_q + AbsW'(p_abs);
        neg_q  <= neg_q + CntW'(p_ext[16]);
        psum_q <= psum_q + DW'(pow_q);
        cnt_q  <= cnt_q + 1'b1;
      end
    end
  end

  assign st_o.cmd        = item_q.command;
  assign st_o.count_zero = (cnt_q == '0);
  assign out_data_o      = out_q;

endmodule
`default_nettype wire

[rtl/bpsk_ctrl.sv]
// Controller: sequences CORDIC passes, accumulation, the two divisions and the result beat.
`default_nettype none
module bpsk_ctrl import bpsk_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = MaxSamplesDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic [1:0] in_cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire st_t  st_i,
  output ctl_t      ctl_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DW   = 32 + CntW;
  localparam int unsigned CW   = $clog2(DW + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_CORDIC = 4'd2;
  localparam logic [3:0] S_ACCUM  = 4'd3;
  localparam logic [3:0] S_DEC    = 4'd4;
  localparam logic [3:0] S_DIVP   = 4'd5;
  localparam logic [3:0] S_GRAB   = 4'd6;
  localparam logic [3:0] S_DIVA   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pass_q, pass_d;
  logic          ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    ov_d    = ov_q && !out_ready_i;
    ctl_o   = '0;
    ctl_o.k = cnt_q[4:0];
    ctl_o.cordic_sel_prev = pass_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          pass_d = 1'b0;
          case (in_cmd_i)
            CMD_SAMPLE, CMD_DIFF: state_d = S_LOAD;
            CMD_DECODE:           state_d = S_DEC;
            default:              ctl_o.clear = 1'b1;
          endcase
        end
      end
      S_LOAD: begin
        ctl_o.cordic_load = 1'b1;
        ctl_o.grab_cur    = pass_q;
        cnt_d   = '0;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        ctl_o.cordic_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          if (st_i.cmd == CMD_DIFF && !pass_q) begin
            pass_d  = 1'b1;
            state_d = S_LOAD;
          end else begin
            state_d = S_ACCUM;
          end
        end
      end
      S_ACCUM: begin
        ctl_o.accum = 1'b1;
        state_d = S_IDLE;
      end
      S_DEC: begin
        if (st_i.count_zero) begin
          state_d = S_OUT;
        end else begin
          ctl_o.div_load_phase = 1'b1;
          cnt_d   = '0;
          state_d = S_DIVP;
        end
      end
      S_DIVP: begin
        ctl_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          state_d = S_GRAB;
        end
      end
      S_GRAB: begin
        ctl_o.div_grab_phase = 1'b1;
        ctl_o.div_load_pow   = 1'b1;
        cnt_d   = '0;
        state_d = S_DIVA;
      end
      S_DIVA: begin
        ctl_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // The result register may still hold an earlier beat.
        if (!ov_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the BPSK symbol decider: directed and random command streams checked against a model.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bpsk_pkg::*;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned CordicSteps = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  bpsk_symbol_decider i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the accumulator state.
  logic [63:0] abs_sum;
  longint signed_sum;
  int unsigned neg_cnt;
  logic [63:0] pow_sum;
  int unsigned acc_cnt;
  logic dropped;

  out_t decisions_q[$];
  int unsigned err_cnt = 0;
  bit rx_busy_stall = 1'b0;

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [15:0] cordic_phase(logic signed [15:0] si, logic signed [15:0] sq);
    longint x, y, xn;
    logic [31:0] z;
    x = si;
    y = sq;
    z = '0;
    if (si == 0 && sq == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    x = x * 65536;
    y = y * 65536;
    for (int k = 0; k < CordicSteps; k++) begin
      if (y >= 0) begin
        xn = x + shr_floor(y, k);
        y = y - shr_floor(x, k);
        z = z + atan_f(k[4:0]);
      end else begin
        xn = x - shr_floor(y, k);
        y = y + shr_floor(x, k);
        z = z - atan_f(k[4:0]);
      end
      x = xn;
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  task automatic clear_sums();
    abs_sum = '0;
    signed_sum = 0;
    neg_cnt = 0;
    pow_sum = '0;
    acc_cnt = 0;
    dropped = 1'b0;
  endtask

  task automatic add_phase(logic [15:0] code, logic signed [15:0] si, logic signed [15:0] sq);
    longint p;
    if (acc_cnt >= MaxSamples) begin
      dropped = 1'b1;
      return;
    end
    p = longint'($signed(code));
    signed_sum += p;
    if (p < 0) begin
      abs_sum += 64'(-p);
      neg_cnt++;
    end else begin
      abs_sum += 64'(p);
    end
    pow_sum += 64'(longint'(si) * si + longint'(sq) * sq);
    acc_cnt++;
  endtask

  task automatic predict_decision(in_t it);
    out_t r;
    longint perr;
    logic [63:0] q;
    r = '0;
    case (cmd_e'(it.command))
      CMD_SAMPLE: add_phase(cordic_phase(it.cur_i, it.cur_q), it.cur_i, it.cur_q);
      CMD_DIFF: add_phase(cordic_phase(it.cur_i, it.cur_q) - cordic_phase(it.prev_i, it.prev_q),
                          it.cur_i, it.cur_q);
      CMD_CLEAR: clear_sums();
      default: begin
        if (acc_cnt == 0) begin
          r.empty_res = 1'b1;
        end else begin
          r.bit_res = abs_sum >= 64'(16384) * acc_cnt;
          perr = signed_sum;
          if (r.bit_res) perr += 32768 * (2 * longint'(neg_cnt) - longint'(acc_cnt));
          perr = perr / longint'(acc_cnt);
          q = pow_sum / acc_cnt;
          r.phase_error = perr[15:0];
          r.amplitude_error = 32'(longint'(q) - 64'sd1073741824);
          r.sample_count = acc_cnt[10:0];
          r.overflow = dropped;
        end
        decisions_q.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  function automatic int idle_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Sends one beat; gaps are optional so some stretches run back to back.
  // Valid stays high after acceptance unless a gap or a drain follows.
  task automatic send_beat(in_t it, bit with_gap);
    int n;
    n = with_gap ? idle_gap() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_decision(it);
  endtask

  function automatic in_t make_beat(cmd_e c, int ci, int cq, int pi_v, int pq);
    in_t it;
    it.command = c;
    it.cur_i = ci[15:0];
    it.cur_q = cq[15:0];
    it.prev_i = pi_v[15:0];
    it.prev_q = pq[15:0];
    return it;
  endfunction

  function automatic in_t rand_beat(cmd_e c);
    return make_beat(c, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Output side: random stalls while rx_busy_stall is set, compare each accepted beat.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (decisions_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = decisions_q.pop_front();
          if (out_data_o.bit_res !== want.bit_res)
            report_mismatch("bit_res", out_data_o.bit_res, want.bit_res);
          if (out_data_o.empty_res !== want.empty_res)
            report_mismatch("empty_res", out_data_o.empty_res, want.empty_res);
          if (out_data_o.phase_error !== want.phase_error)
            report_mismatch("phase_error", out_data_o.phase_error, want.phase_error);
          if (out_data_o.amplitude_error !== want.amplitude_error)
            report_mismatch("amplitude_error", out_data_o.amplitude_error,
                            want.amplitude_error);
          if (out_data_o.sample_count !== want.sample_count)
            report_mismatch("sample_count", out_data_o.sample_count, want.sample_count);
          if (out_data_o.overflow !== want.overflow)
            report_mismatch("overflow", out_data_o.overflow, want.overflow);
        end
      end
      if (rx_busy_stall)
        out_ready_i <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      else
        out_ready_i <= 1'b1;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decisions_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int ext[5] = '{-32768, -1, 0, 1, 32767};
    send_beat(make_beat(CMD_DECODE, 0, 0, 0, 0), 1'b0);
    send_beat(make_beat(CMD_SAMPLE, 0, 0, 0, 0), 1'b1);
    send_beat(make_beat(CMD_SAMPLE, 32767, 0, 0, 0), 1'b1);
    send_beat(make_beat(CMD_DECODE, 0, 0, 0, 0), 1'b1);
    foreach (ext[k]) send_beat(make_beat(CMD_SAMPLE, ext[k], ext[4 - k], 0, 0), 1'b0);
    send_beat(make_beat(CMD_SAMPLE, -32768, 0, 0, 0), 1'b1);
    send_beat(make_beat(CMD_SAMPLE, -32768, -1, 0, 0), 1'b1);
    send_beat(make_beat(CMD_DIFF, 100, 200, 0, 0), 1'b1);
    send_beat(make_beat(CMD_DIFF, -32768, 1, 32767, -1), 1'b1);
    send_beat(make_beat(CMD_DIFF, 32767, 32767, -32768, -32768), 1'b0);
    send_beat(make_beat(CMD_DECODE, -1, -1, -1, -1), 1'b1);
    send_beat(make_beat(CMD_CLEAR, 5, 5, 5, 5), 1'b1);
    send_beat(make_beat(CMD_DECODE, 0, 0, 0, 0), 1'b1);
    send_beat(make_beat(CMD_SAMPLE, -20000, 3, 0, 0), 1'b0);
    send_beat(make_beat(CMD_SAMPLE, -20000, -3, 0, 0), 1'b0);
    send_beat(make_beat(CMD_DECODE, 0, 0, 0, 0), 1'b1);
    send_beat(make_beat(CMD_CLEAR, 0, 0, 0, 0), 1'b1);
  endtask

  // Fills past the maximum, so the dropped-sample flag shows and clears.
  task automatic test_overflow();
    for (int n = 0; n < MaxSamples + 3; n++)
      send_beat(rand_beat($urandom_range(0, 1) ? CMD_SAMPLE : CMD_DIFF), n[5:0] == 0);
    send_beat(rand_beat(CMD_DECODE), 1'b1);
    send_beat(rand_beat(CMD_CLEAR), 1'b1);
    send_beat(rand_beat(CMD_DECODE), 1'b1);
  endtask

  // Symbols of a few samples near one point, with noise and stray commands.
  task automatic test_random_symbols();
    int amp, sgn, ci, cq;
    rx_busy_stall = 1'b1;
    for (int s = 0; s < 70; s++) begin
      amp = $urandom_range(1000, 32767);
      sgn = $urandom_range(0, 1) ? 1 : -1;
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 4) == 0) begin
          send_beat(rand_beat($urandom_range(0, 1) ? CMD_SAMPLE : CMD_DIFF), 1'b1);
        end else begin
          ci = sgn * amp + $signed($urandom_range(0, 4000)) - 2000;
          cq = $signed($urandom_range(0, 8000)) - 4000;
          if (ci > 32767) ci = 32767;
          if (ci < -32768) ci = -32768;
          send_beat(make_beat($urandom_range(0, 2) ? CMD_SAMPLE : CMD_DIFF, ci, cq,
                              (s[0] ? amp : -amp), cq), $urandom_range(0, 1));
        end
      end
      send_beat(rand_beat(CMD_DECODE), 1'b1);
      if (s == 35) wait_drained();
      if ($urandom_range(0, 3) != 0) send_beat(rand_beat(CMD_CLEAR), 1'b0);
    end
  endtask

  initial begin
    clear_sums();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random_symbols();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && decisions_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/bpsk_pkg.sv
rtl/bpsk_datapath.sv
rtl/bpsk_ctrl.sv
rtl/bpsk_symbol_decider.sv
sim/tb.sv
